// File: src/m3inv_pkg.sv
// ----------------------------------------------------------------------------
// m3inv_pkg
// Shared types and constants for the 3x3 matrix inverse pipeline.
// ----------------------------------------------------------------------------
package m3inv_pkg;

  localparam int NUM_ELEMS = 9;

  // Register stages ahead of the dividers: products, cofactors,
  // determinant partial products and determinant sum.
  localparam int TOP_STAGES = 4;

  // Divider stages that are not quotient bit steps: operand magnitudes,
  // operand scaling, range check and the final sign and saturation stage.
  localparam int DIV_FIXED_STAGES = 4;

  typedef logic [3:0] elem_idx_t;

  // Cofactor k is e[a]*e[b] - e[c]*e[d], elements numbered row by row.
  localparam elem_idx_t ADJ_TERMS [NUM_ELEMS][4] = '{
    '{4'd4, 4'd8, 4'd5, 4'd7}, '{4'd2, 4'd7, 4'd1, 4'd8}, '{4'd1, 4'd5, 4'd2, 4'd4},
    '{4'd5, 4'd6, 4'd3, 4'd8}, '{4'd0, 4'd8, 4'd2, 4'd6}, '{4'd2, 4'd3, 4'd0, 4'd5},
    '{4'd3, 4'd7, 4'd4, 4'd6}, '{4'd1, 4'd6, 4'd0, 4'd7}, '{4'd0, 4'd4, 4'd1, 4'd3}
  };

endpackage

// File: src/m3inv_div.sv
// ----------------------------------------------------------------------------
// m3inv_div
// Pipelined restoring divider: one cofactor over the determinant, scaled,
// rounded half away from zero and saturated to the element range.
// ----------------------------------------------------------------------------
module m3inv_div #(
  parameter int ELEM_WIDTH = 32,
  parameter int FRAC_BITS  = 16,
  parameter int ADJ_W      = 65,
  parameter int DET_W      = 99
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic signed [ADJ_W-1:0]       adj_i,
  input  logic signed [DET_W-1:0]       det_i,
  output logic signed [ELEM_WIDTH-1:0]  q_o
);

  localparam int RA = ADJ_W + 2*FRAC_BITS + 2;
  localparam int RB = DET_W + ELEM_WIDTH + 1;
  localparam int XW = (RA > RB) ? RA : RB;
  localparam int QW = ELEM_WIDTH - 1;

  logic [ADJ_W-1:0] na_d, na_q;
  logic [DET_W-1:0] nd_d, nd_q;
  logic             neg0_q, neg1_q;
  logic [XW-1:0]    num_q, den_q;

  logic [XW-1:0]    rem_q [QW];
  logic [XW-1:0]    dv_q  [QW];
  logic [QW-1:0]    qb_q  [ELEM_WIDTH];
  logic             neg_q [ELEM_WIDTH];
  logic             sat_q [ELEM_WIDTH];

  logic [ELEM_WIDTH-1:0] res_d, res_q;

  assign na_d = adj_i[ADJ_W-1] ? (~adj_i + ADJ_W'(1)) : adj_i;
  assign nd_d = det_i[DET_W-1] ? (~det_i + DET_W'(1)) : det_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      na_q   <= na_d;
      nd_q   <= nd_d;
      neg0_q <= adj_i[ADJ_W-1] ^ det_i[DET_W-1];
      // Adding the divisor to twice the scaled numerator rounds halves outward.
      num_q  <= (XW'(na_q) << (2*FRAC_BITS + 1)) + XW'(nd_q);
      den_q  <= XW'(nd_q) << 1;
      neg1_q <= neg0_q;
      rem_q[0] <= num_q;
      dv_q[0]  <= den_q;
      qb_q[0]  <= '0;
      neg_q[0] <= neg1_q;
      sat_q[0] <= (num_q >= (den_q << (ELEM_WIDTH - 1)));
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_bit
    localparam int B = QW - 1 - k;
    logic [XW-1:0] shd;
    logic          ge;
    logic [QW-1:0] qn;

    assign shd = dv_q[k] << B;
    assign ge  = (rem_q[k] >= shd);

    always_comb begin
      qn    = qb_q[k];
      qn[B] = ge;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        qb_q[k+1]  <= qn;
        neg_q[k+1] <= neg_q[k];
        sat_q[k+1] <= sat_q[k];
      end
    end

    // The last bit step leaves no remainder behind.
    if (k < QW - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k+1] <= ge ? (rem_q[k] - shd) : rem_q[k];
          dv_q[k+1]  <= dv_q[k];
        end
      end
    end
  end

  always_comb begin
    if (sat_q[QW]) begin
      res_d = neg_q[QW] ? {1'b1, {QW{1'b0}}} : {1'b0, {QW{1'b1}}};
    end else if (neg_q[QW]) begin
      res_d = ~{1'b0, qb_q[QW]} + ELEM_WIDTH'(1);
    end else begin
      res_d = {1'b0, qb_q[QW]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign q_o = res_q;

endmodule

// File: src/matrix3x3_inverse.sv
// ----------------------------------------------------------------------------
// matrix3x3_inverse
// Inverse of a signed fixed-point 3x3 matrix by the adjugate method.
// ----------------------------------------------------------------------------
// The block takes one matrix word per cycle while the output is not stalled
// and returns its inverse, rounded half away from zero and saturated; the
// path holds ELEM_WIDTH + 7 register stages. Four stages form the cofactors
// and the determinant; nine restoring dividers then produce one quotient
// bit per stage, so the divider depth sets the latency. A singular matrix
// returns all-zero elements with tuser set. Back-pressure on the output
// holds the whole pipeline.
module matrix3x3_inverse
  import m3inv_pkg::*;
#(
  parameter int ELEM_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        s_axis_tvalid_i,
  output logic                                        s_axis_tready_o,
  // m11, m12, m13, m21, m22, m23, m31, m32, m33 from the lowest bit up
  input  logic [((NUM_ELEMS*ELEM_WIDTH+7)/8)*8-1:0]   s_axis_tdata_i,
  output logic                                        m_axis_tvalid_o,
  input  logic                                        m_axis_tready_i,
  // r11, r12, r13, r21, r22, r23, r31, r32, r33 from the lowest bit up
  output logic [((NUM_ELEMS*ELEM_WIDTH+7)/8)*8-1:0]   m_axis_tdata_o,
  // singular
  output logic                                        m_axis_tuser_o
);

  localparam int W   = ELEM_WIDTH;
  localparam int AW  = 2*W + 1;
  localparam int DTW = 3*W + 3;
  localparam int LD  = W - 1 + DIV_FIXED_STAGES;
  localparam int NV  = TOP_STAGES + LD;

  logic en;
  logic [NV-1:0] vld_q;

  logic signed [W-1:0]   e_in  [NUM_ELEMS];
  logic signed [2*W-1:0] pa_q  [NUM_ELEMS];
  logic signed [2*W-1:0] pb_q  [NUM_ELEMS];
  logic signed [W-1:0]   ec1_q [3];
  logic signed [W-1:0]   ec2_q [3];
  logic signed [AW-1:0]  adj_q  [NUM_ELEMS];
  logic signed [AW-1:0]  adj3_q [NUM_ELEMS];
  logic signed [AW-1:0]  adj4_q [NUM_ELEMS];
  logic signed [2*W:0]   pl_q [3];
  logic signed [2*W:0]   ph_q [3];
  logic signed [DTW-1:0] det_d, det_q;
  logic [LD-1:0]         sing_q;
  logic signed [W-1:0]   res [NUM_ELEMS];

  // A stage advances whenever the output register is free or being emptied.
  assign en              = !vld_q[NV-1] || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign m_axis_tvalid_o = vld_q[NV-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NV-2:0], s_axis_tvalid_i};
    end
  end

  for (genvar k = 0; k < NUM_ELEMS; k++) begin : g_elem
    assign e_in[k] = s_axis_tdata_i[k*W +: W];

    always_ff @(posedge clk_i) begin
      if (en) begin
        pa_q[k]   <= e_in[ADJ_TERMS[k][0]] * e_in[ADJ_TERMS[k][1]];
        pb_q[k]   <= e_in[ADJ_TERMS[k][2]] * e_in[ADJ_TERMS[k][3]];
        adj_q[k]  <= {pa_q[k][2*W-1], pa_q[k]} - {pb_q[k][2*W-1], pb_q[k]};
        adj3_q[k] <= adj_q[k];
        adj4_q[k] <= adj3_q[k];
      end
    end

    m3inv_div #(
      .ELEM_WIDTH (W),
      .FRAC_BITS  (FRAC_BITS),
      .ADJ_W      (AW),
      .DET_W      (DTW)
    ) u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .adj_i (adj4_q[k]),
      .det_i (det_q),
      .q_o   (res[k])
    );
  end

  // First-column expansion; each term is split into two narrower products.
  for (genvar j = 0; j < 3; j++) begin : g_det
    always_ff @(posedge clk_i) begin
      if (en) begin
        ec1_q[j] <= e_in[3*j];
        ec2_q[j] <= ec1_q[j];
        pl_q[j]  <= ec2_q[j] * $signed({1'b0, adj_q[j][W-1:0]});
        ph_q[j]  <= ec2_q[j] * $signed(adj_q[j][AW-1:W]);
      end
    end
  end

  always_comb begin
    det_d = '0;
    for (int j = 0; j < 3; j++) begin
      det_d = det_d + (DTW'(ph_q[j]) <<< W) + DTW'(pl_q[j]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      det_q  <= det_d;
      sing_q <= {sing_q[LD-2:0], (det_q == '0)};
    end
  end

  always_comb begin
    m_axis_tdata_o = '0;
    for (int k = 0; k < NUM_ELEMS; k++) begin
      m_axis_tdata_o[k*W +: W] = sing_q[LD-1] ? '0 : res[k];
    end
  end

  assign m_axis_tuser_o = sing_q[LD-1];

  a_sing_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> (m_axis_tdata_o == '0))
    else $error("singular word carries non-zero elements");

  a_stall_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline moved while stalled");

  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i)
    else $error("input held off without a waiting output word");

endmodule
